@@ sv/arb_pkg.sv @@
// Shared codes and fixed-point constants for the affine rectangle bounds block.
package arb_pkg;

  // Q4.12 coefficients: fraction bits, unity gain and round-to-nearest bias
  localparam int unsigned COEF_FRAC  = 12;
  localparam int unsigned COEF_ONE   = 1 << COEF_FRAC;
  localparam int unsigned ROUND_BIAS = 1 << (COEF_FRAC - 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;

  typedef enum logic {
    MODE_POINT = 1'b0,
    MODE_RECT  = 1'b1
  } mode_t;

endpackage

@@ sv/affine_rect_bounds.sv @@
// Affine transform of points and rectangles with axis-aligned bounding box output.
//
// Usage:
//   Input words (in_mode, in_x, in_y, in_w, in_h) enter on in_valid/in_stall,
//   result words (out_x, out_y, out_w, out_h) leave on out_valid/out_stall.
//   A word moves on a rising edge with valid high and stall low.
//   Point mode gives the transformed point with zero width and height; rect
//   mode transforms the four corners and gives their bounding box.
//   The matrix sits in six registers written through cfg_we/cfg_index/
//   cfg_wdata; write them only while no word is in flight.
// Timing:
//   Six register stages: input, products, sums, corners, box, output. A word
//   moves through them in that order. One word is accepted per cycle while
//   in_stall is low; the eight multipliers work in parallel in one stage.
// Reset (synchronous, rst_n low): pipeline empties, matrix returns to
//   identity with zero translation.
// Stall: each stage holds while full and the stage after it cannot take its
//   word, so bubbles close up; in_stall rises only once the input stage is
//   full and blocked.
module affine_rect_bounds
  import arb_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int COEF_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [((COORD_BITS > COEF_BITS) ? COORD_BITS : COEF_BITS)-1:0] cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_mode,
  input  logic signed [COORD_BITS-1:0]          in_x,
  input  logic signed [COORD_BITS-1:0]          in_y,
  input  logic        [COORD_BITS-2:0]          in_w,
  input  logic        [COORD_BITS-2:0]          in_h,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [COORD_BITS-1:0]          out_x,
  output logic signed [COORD_BITS-1:0]          out_y,
  output logic        [COORD_BITS-1:0]          out_w,
  output logic        [COORD_BITS-1:0]          out_h
);

  localparam int CW   = COORD_BITS;
  localparam int KW   = COEF_BITS;
  localparam int PW   = CW + KW;             // one product
  localparam int SW   = PW + 2;              // up to four products plus bias
  localparam int QW   = SW - COEF_FRAC;      // after the rounding shift
  localparam int TW   = QW + 1;              // plus translation
  localparam int NSTG = 6;

  localparam logic signed [SW-1:0] BIAS    = SW'(ROUND_BIAS);
  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  // configuration registers
  logic signed [KW-1:0] coef_xx_r, coef_yx_r, coef_xy_r, coef_yy_r;
  logic signed [CW-1:0] shift_x_r, shift_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_xx_r <= KW'(COEF_ONE);
      coef_yx_r <= '0;
      coef_xy_r <= '0;
      coef_yy_r <= KW'(COEF_ONE);
      shift_x_r <= '0;
      shift_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_XX: coef_xx_r <= cfg_wdata[KW-1:0];
        REG_COEF_YX: coef_yx_r <= cfg_wdata[KW-1:0];
        REG_COEF_XY: coef_xy_r <= cfg_wdata[KW-1:0];
        REG_COEF_YY: coef_yy_r <= cfg_wdata[KW-1:0];
        REG_SHIFT_X: shift_x_r <= cfg_wdata[CW-1:0];
        REG_SHIFT_Y: shift_y_r <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when empty or when its word moves on
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;
  mode_t           mode_r [NSTG];

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) mode_r[0] <= mode_t'(in_mode);
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) mode_r[k] <= mode_r[k-1];
    end
  end

  // stage 0: input register
  logic signed [CW-1:0] x0_r, y0_r;
  logic        [CW-2:0] w0_r, h0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0_r <= in_x;
      y0_r <= in_y;
      w0_r <= in_w;
      h0_r <= in_h;
    end
  end

  // stage 1: eight products; x+w and y+h split by linearity
  logic signed [CW-1:0] w0_ext, h0_ext;
  logic signed [PW-1:0] pxx_r, pxy_r, pxw_r, pxh_r;
  logic signed [PW-1:0] pyx_r, pyy_r, pyw_r, pyh_r;

  assign w0_ext = $signed({1'b0, w0_r});
  assign h0_ext = $signed({1'b0, h0_r});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pxx_r <= PW'(coef_xx_r) * PW'(x0_r);
      pxy_r <= PW'(coef_xy_r) * PW'(y0_r);
      pxw_r <= PW'(coef_xx_r) * PW'(w0_ext);
      pxh_r <= PW'(coef_xy_r) * PW'(h0_ext);
      pyx_r <= PW'(coef_yx_r) * PW'(x0_r);
      pyy_r <= PW'(coef_yy_r) * PW'(y0_r);
      pyw_r <= PW'(coef_yx_r) * PW'(w0_ext);
      pyh_r <= PW'(coef_yy_r) * PW'(h0_ext);
    end
  end

  // stage 2: exact corner sums with rounding bias
  // corner order: (x,y), (x+w,y), (x+w,y+h), (x,y+h)
  logic signed [SW-1:0] ax, ay;
  logic signed [SW-1:0] sx_r [4];
  logic signed [SW-1:0] sy_r [4];

  assign ax = SW'(pxx_r) + SW'(pxy_r) + BIAS;
  assign ay = SW'(pyx_r) + SW'(pyy_r) + BIAS;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sx_r[0] <= ax;
      sx_r[1] <= ax + SW'(pxw_r);
      sx_r[2] <= ax + SW'(pxw_r) + SW'(pxh_r);
      sx_r[3] <= ax + SW'(pxh_r);
      sy_r[0] <= ay;
      sy_r[1] <= ay + SW'(pyw_r);
      sy_r[2] <= ay + SW'(pyw_r) + SW'(pyh_r);
      sy_r[3] <= ay + SW'(pyh_r);
    end
  end

  // stage 3: floor shift, translate, saturate
  function automatic logic signed [CW-1:0] round_sat(input logic signed [SW-1:0] s,
                                                     input logic signed [CW-1:0] t);
    logic signed [QW-1:0] q;
    logic signed [TW-1:0] v;
    logic        [TW-CW:0] top;
    q   = s[SW-1:COEF_FRAC];
    v   = TW'(q) + TW'(t);
    top = v[TW-1:CW-1];
    if (top == '0 || top == '1) begin
      return v[CW-1:0];
    end
    return v[TW-1] ? SAT_MIN : SAT_MAX;
  endfunction

  logic signed [CW-1:0] cx_r [4];
  logic signed [CW-1:0] cy_r [4];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 4; i++) begin
        cx_r[i] <= round_sat(sx_r[i], shift_x_r);
        cy_r[i] <= round_sat(sy_r[i], shift_y_r);
      end
    end
  end

  // stage 4: box extremes; a point collapses to its first corner
  function automatic logic signed [CW-1:0] min2(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [CW-1:0] max2(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (b > a) ? b : a;
  endfunction

  logic signed [CW-1:0] minx_r, maxx_r, miny_r, maxy_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      if (mode_r[3] == MODE_POINT) begin
        minx_r <= cx_r[0];
        maxx_r <= cx_r[0];
        miny_r <= cy_r[0];
        maxy_r <= cy_r[0];
      end else begin
        minx_r <= min2(min2(cx_r[0], cx_r[1]), min2(cx_r[2], cx_r[3]));
        maxx_r <= max2(max2(cx_r[0], cx_r[1]), max2(cx_r[2], cx_r[3]));
        miny_r <= min2(min2(cy_r[0], cy_r[1]), min2(cy_r[2], cy_r[3]));
        maxy_r <= max2(max2(cy_r[0], cy_r[1]), max2(cy_r[2], cy_r[3]));
      end
    end
  end

  // stage 5: output word; extent never exceeds the unsigned coordinate range
  logic signed [CW:0] dw, dh;

  assign dw = (CW+1)'(maxx_r) - (CW+1)'(minx_r);
  assign dh = (CW+1)'(maxy_r) - (CW+1)'(miny_r);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_x <= minx_r;
      out_y <= miny_r;
      out_w <= dw[CW-1:0];
      out_h <= dh[CW-1:0];
    end
  end

  // checks
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> vld_r[0])
    else $error("input stalled while the input stage is empty");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted word did not reach the input stage");

  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (minx_r <= maxx_r) && (miny_r <= maxy_r))
    else $error("box minimum above maximum");

  a_point_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && mode_r[5] == MODE_POINT) |-> (out_w == '0) && (out_h == '0))
    else $error("point word with nonzero size");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(mode_r[5]))
    else $error("stalled output word dropped");

endmodule
